### sv/b64sc_pkg.sv
// Shared types, codes and alphabet functions of the base64 stream codec.
package b64sc_pkg;

   // Direction register codes
   typedef enum logic {
      DIR_ENCODE = 1'b0,
      DIR_DECODE = 1'b1
   } dir_type;

   // Error codes reported on the final word of a message
   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_COUNT = 2'd1;
   localparam logic [1:0] ERR_PAD   = 2'd2;

   localparam logic [7:0] PAD_CHAR = 8'h3d;  // '='
   localparam int unsigned SLOTS = 4;        // most result words one input can cause

   // One result word as held in the output queue
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       last_result;
      logic [1:0] error_code;
   } rsp_slot_type;

   // Classified input character for decoding
   typedef struct packed {
      logic       is_sym;   // alphabet character or pad
      logic       is_pad;   // '='
      logic [5:0] value;    // sextet, zero for a pad
   } sym_type;

   // Map a sextet to its alphabet character
   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2b;
      end else begin
         c = 8'h2f;
      end
      return c;
   endfunction

   // Classify a character: sextet value, pad, or skipped
   function automatic sym_type dec_char(input logic [7:0] c);
      sym_type s;
      s = '0;
      if (c >= 8'h41 && c <= 8'h5a) begin
         s.is_sym = 1'b1;
         s.value  = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         s.is_sym = 1'b1;
         s.value  = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         s.is_sym = 1'b1;
         s.value  = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2b) begin
         s.is_sym = 1'b1;
         s.value  = 6'd62;
      end else if (c == 8'h2f) begin
         s.is_sym = 1'b1;
         s.value  = 6'd63;
      end else if (c == PAD_CHAR) begin
         s.is_sym = 1'b1;
         s.is_pad = 1'b1;
      end
      return s;
   endfunction

endpackage

### sv/base64_stream_codec_top.sv
// Top level of the base64 stream codec: input register, group logic, result queue.
//
// Usage: req_* is the input stream, one word per byte or character, with
// req_tlast on the final word of a message. rsp_* carries result words:
// rsp_tdata is the character or decoded byte, rsp_tuser holds has_byte and
// the error code, rsp_tlast marks the final word of a message. csr_* writes
// the direction bit (0 encode, 1 decode); a write also clears the message
// state; the user must make it only while the codec is idle (not enforced).
// Order: an input word lands in the input register and is processed from
// there once it may; its results are then loaded into the result queue.
// Throughput: one word per cycle on either side unless the receiver stalls
// or an input waits for room. An input that yields no result passes through
// at once; one that yields results waits until the four-entry result queue
// is empty or losing its last word; encoding is bound by the single result port.
// Decoding sustains one character per cycle except behind a full group.
// Reset clears the direction to encode, the message state and both the
// input register and the result queue. When the receiver stalls, the queue
// holds, then the input register fills and req_tready drops.
module base64_stream_codec_top (
   input  logic       clock,
   input  logic       reset,
   // input stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // message_end
   // result stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser,   // [0] has_byte, [2:1] error_code
   output logic       rsp_tlast,   // last_result
   // configuration write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data     // direction
);
   import b64sc_pkg::*;

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // message state
   dir_type     dir_ff, dir_in;
   logic [23:0] gb_ff, gb_in;
   logic [1:0]  gcnt_ff, gcnt_in;
   logic [1:0]  pad_ff, pad_in;
   logic [1:0]  smod_ff, smod_in;
   logic        any_ff, any_in;
   logic        fin_ff, fin_in;
   logic [1:0]  errs_ff, errs_in;

   // result queue, word 0 at the head
   rsp_slot_type slot_ff [SLOTS];
   rsp_slot_type slot_in [SLOTS];
   logic [2:0]   cnt_ff, cnt_in;

   // step results
   rsp_slot_type res [SLOTS];
   logic [2:0]   n_res;
   logic [23:0]  st_gb;
   logic [1:0]   st_gcnt, st_pad, st_smod, st_errs;
   logic         st_any, st_fin;

   logic        rsp_pop, room, proc, accept, csr_wr;
   sym_type     sym;
   logic [23:0] enc_gb, enc_bits, dec_gb;
   logic [1:0]  pad_nx, keep, err;
   logic [1:0]  last_idx;

   assign csr_ready  = 1'b1;
   assign csr_wr     = csr_valid & csr_ready;
   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_pop    = rsp_tvalid & rsp_tready;
   assign room       = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_pop);
   assign proc       = in_vld_ff && ((n_res == 3'd0) || room);
   assign req_tready = !in_vld_ff || proc;
   assign accept     = req_tvalid & req_tready;

   assign rsp_tdata = slot_ff[0].out_byte;
   assign rsp_tuser = {slot_ff[0].error_code, slot_ff[0].has_byte};
   assign rsp_tlast = slot_ff[0].last_result;

   // work out one input word against the message state
   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         res[k] = '0;
      end
      n_res    = 3'd0;
      st_gb    = gb_ff;
      st_gcnt  = gcnt_ff;
      st_pad   = pad_ff;
      st_smod  = smod_ff;
      st_any   = any_ff;
      st_fin   = fin_ff;
      st_errs  = errs_ff;
      sym      = dec_char(in_byte_ff);
      enc_gb   = {gb_ff[15:0], in_byte_ff};
      enc_bits = (gcnt_ff == 2'd0) ? {in_byte_ff, 16'h0000}
                                   : {gb_ff[7:0], in_byte_ff, 8'h00};
      pad_nx   = (sym.is_pad && pad_ff != 2'd3) ? pad_ff + 2'd1 : pad_ff;
      dec_gb   = {gb_ff[17:0], sym.value};
      keep     = 2'd3 - pad_nx;
      err      = ERR_OK;

      if (dir_ff == DIR_ENCODE) begin
         // collect bytes, emit four characters per full or final group
         st_gb   = enc_gb;
         st_gcnt = gcnt_ff + 2'd1;
         if (gcnt_ff == 2'd2) begin
            for (int k = 0; k < SLOTS; k++) begin
               res[k].out_byte = enc_char(enc_gb[18 - 6 * k +: 6]);
               res[k].has_byte = 1'b1;
            end
            n_res   = 3'd4;
            st_gb   = '0;
            st_gcnt = 2'd0;
         end else if (in_end_ff) begin
            for (int k = 0; k < SLOTS; k++) begin
               res[k].out_byte = enc_char(enc_bits[18 - 6 * k +: 6]);
               res[k].has_byte = 1'b1;
            end
            if (gcnt_ff == 2'd0) begin
               res[2].out_byte = PAD_CHAR;
            end
            res[3].out_byte = PAD_CHAR;
            n_res = 3'd4;
         end
      end else begin
         // count symbols, emit up to three bytes per full group
         if (sym.is_sym) begin
            st_smod = smod_ff + 2'd1;
            st_any  = 1'b1;
            if (!fin_ff) begin
               st_pad = pad_nx;
               st_gb  = dec_gb;
               if (gcnt_ff == 2'd3) begin
                  for (int k = 0; k < 3; k++) begin
                     res[k].out_byte = dec_gb[16 - 8 * k +: 8];
                     res[k].has_byte = 1'b1;
                  end
                  n_res = {1'b0, keep};
                  if (pad_nx != 2'd0) begin
                     st_fin = 1'b1;
                  end
                  if (pad_nx == 2'd3) begin
                     st_errs = ERR_PAD;
                  end
                  st_gb   = '0;
                  st_gcnt = 2'd0;
                  st_pad  = 2'd0;
               end else begin
                  st_gcnt = gcnt_ff + 2'd1;
               end
            end
         end
         if (in_end_ff) begin
            err = (!st_any || st_smod != 2'd0) ? ERR_COUNT : st_errs;
            if (n_res == 3'd0) begin
               res[0] = '0;
               n_res  = 3'd1;
            end
         end
      end

      // mark the final word of the message and clear the message state
      last_idx = 2'(n_res - 3'd1);
      if (in_end_ff) begin
         res[last_idx].last_result = 1'b1;
         res[last_idx].error_code  = err;
         st_gb   = '0;
         st_gcnt = 2'd0;
         st_pad  = 2'd0;
         st_smod = 2'd0;
         st_any  = 1'b0;
         st_fin  = 1'b0;
         st_errs = ERR_OK;
      end
   end

   // next message state: a direction write clears, otherwise advance on process
   always_comb begin
      dir_in  = dir_ff;
      gb_in   = gb_ff;
      gcnt_in = gcnt_ff;
      pad_in  = pad_ff;
      smod_in = smod_ff;
      any_in  = any_ff;
      fin_in  = fin_ff;
      errs_in = errs_ff;
      if (csr_wr) begin
         dir_in  = dir_type'(csr_data);
         gb_in   = '0;
         gcnt_in = 2'd0;
         pad_in  = 2'd0;
         smod_in = 2'd0;
         any_in  = 1'b0;
         fin_in  = 1'b0;
         errs_in = ERR_OK;
      end else if (proc) begin
         gb_in   = st_gb;
         gcnt_in = st_gcnt;
         pad_in  = st_pad;
         smod_in = st_smod;
         any_in  = st_any;
         fin_in  = st_fin;
         errs_in = st_errs;
      end
   end

   // next queue contents: load a fresh group or shift out the head
   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         slot_in[k] = slot_ff[k];
      end
      cnt_in = cnt_ff;
      if (proc && n_res != 3'd0) begin
         for (int k = 0; k < SLOTS; k++) begin
            slot_in[k] = res[k];
         end
         cnt_in = n_res;
      end else if (rsp_pop) begin
         for (int k = 0; k < SLOTS - 1; k++) begin
            slot_in[k] = slot_ff[k + 1];
         end
         cnt_in = cnt_ff - 3'd1;
      end
   end

   assign in_vld_in = accept || (in_vld_ff && !proc);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         cnt_ff    <= 3'd0;
         dir_ff    <= DIR_ENCODE;
         gb_ff     <= '0;
         gcnt_ff   <= 2'd0;
         pad_ff    <= 2'd0;
         smod_ff   <= 2'd0;
         any_ff    <= 1'b0;
         fin_ff    <= 1'b0;
         errs_ff   <= ERR_OK;
      end else begin
         in_vld_ff <= in_vld_in;
         cnt_ff    <= cnt_in;
         dir_ff    <= dir_in;
         gb_ff     <= gb_in;
         gcnt_ff   <= gcnt_in;
         pad_ff    <= pad_in;
         smod_ff   <= smod_in;
         any_ff    <= any_in;
         fin_ff    <= fin_in;
         errs_ff   <= errs_in;
      end
   end

   // payload registers: hold the input word and the queued results
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
      for (int k = 0; k < SLOTS; k++) begin
         slot_ff[k] <= slot_in[k];
      end
   end

endmodule
